// ----- rtl/stretched_mandelbrot_pixel_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// stretched_mandelbrot_pixel_engine_top_macros
// Assertion macros for the pixel engine; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef STRETCHED_MANDELBROT_PIXEL_ENGINE_TOP_MACROS_SVH
`define STRETCHED_MANDELBROT_PIXEL_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SMPE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define SMPE_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SMPE_ASSERT(label, clk, rst, prop)
`define SMPE_ASSERT_NR(label, clk, prop)
`endif
`endif

// ----- rtl/smpe_pkg.sv -----
// ----------------------------------------------------------------------------
// smpe_pkg
// Types, constants and helpers shared by the pixel engine modules.
// ----------------------------------------------------------------------------
package smpe_pkg;
  localparam int FRAC_BITS  = 24;
  localparam int COUNT_BITS = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CSCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COFFS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd7;

  typedef struct packed {
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_d;
    logic [47:0]        escape_sq;
    logic [15:0]        max_iter;
    logic [15:0]        colour_scale;
    logic [10:0]        colour_offset;
    logic [16:0]        sample_weight;
  } cfg_regs_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic signed [31:0]  point_re;
    logic signed [31:0]  point_im;
    logic                last_sample;
    logic [COUNT_BITS-1:0] limit;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_CHECK, ST_LIN, ST_LINSUM, ST_SQ, ST_SQMUL, ST_SQSUM,
    ST_HUE, ST_MOD, ST_WEIGHT, ST_ACC, ST_EMIT
  } eng_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

// ----- rtl/smpe_front.sv -----
// ----------------------------------------------------------------------------
// smpe_front
// Register file, input acceptance and a two-entry job queue.
// ----------------------------------------------------------------------------
`include "stretched_mandelbrot_pixel_engine_top_macros.svh"
module smpe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  smpe_pkg::cfg_item_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smpe_pkg::in_item_t   in_data,
  output smpe_pkg::cfg_regs_t  regs,
  output logic                 job_valid,
  input  logic                 job_ready,
  output smpe_pkg::job_t       job
);
  smpe_pkg::job_t q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  smpe_pkg::job_t new_job;
  logic push, pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = (fill != 2'd2);
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;
  assign job_valid = (fill != 2'd0);
  assign job       = q[rd_ptr];

  always_comb begin
    new_job.point_re    = in_data.point_re;
    new_job.point_im    = in_data.point_im;
    new_job.last_sample = in_data.last_sample;
    // saturate the limit to the counter range
    if (regs.max_iter > 16'((1 << smpe_pkg::COUNT_BITS) - 1))
      new_job.limit = smpe_pkg::COUNT_BITS'((1 << smpe_pkg::COUNT_BITS) - 1);
    else
      new_job.limit = smpe_pkg::COUNT_BITS'(regs.max_iter);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coef_a        <= 32'sd16777216;
      regs.coef_b        <= '0;
      regs.coef_d        <= 32'sd16777216;
      regs.escape_sq     <= 48'd67108864;
      regs.max_iter      <= 16'd255;
      regs.colour_scale  <= 16'd256;
      regs.colour_offset <= '0;
      regs.sample_weight <= 17'd65536;
    end else if (cfg_valid) begin
      unique case (cfg.index)
        smpe_pkg::REG_COEF_A: regs.coef_a        <= cfg.data[31:0];
        smpe_pkg::REG_COEF_B: regs.coef_b        <= cfg.data[31:0];
        smpe_pkg::REG_COEF_D: regs.coef_d        <= cfg.data[31:0];
        smpe_pkg::REG_ESCAPE: regs.escape_sq     <= cfg.data[47:0];
        smpe_pkg::REG_MAXIT:  regs.max_iter      <= cfg.data[15:0];
        smpe_pkg::REG_CSCALE: regs.colour_scale  <= cfg.data[15:0];
        smpe_pkg::REG_COFFS:  regs.colour_offset <= cfg.data[10:0];
        smpe_pkg::REG_WEIGHT: regs.sample_weight <= cfg.data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= new_job;
  end

  `SMPE_ASSERT(a_no_overfill, clk, rst, fill <= 2'd2)
  `SMPE_ASSERT(a_pop_nonempty, clk, rst, pop |-> fill != 2'd0)
  `SMPE_ASSERT(a_fill_track, clk, rst, (push && !pop && fill == 2'd1) |=> fill == 2'd2)
endmodule

// ----- rtl/smpe_back.sv -----
// ----------------------------------------------------------------------------
// smpe_back
// Escape loop on one shared set of three multipliers, hue ramp and accumulation.
// ----------------------------------------------------------------------------
`include "stretched_mandelbrot_pixel_engine_top_macros.svh"
module smpe_back (
  input  logic                clk,
  input  logic                rst,
  input  smpe_pkg::cfg_regs_t regs,
  input  logic                job_valid,
  output logic                job_ready,
  input  smpe_pkg::job_t      job,
  output logic                out_valid,
  input  logic                out_ready,
  output smpe_pkg::out_item_t out_data
);
  localparam int F = smpe_pkg::FRAC_BITS;
  localparam int CB = smpe_pkg::COUNT_BITS;
  // hue mod 1536: reduce hue / 512 mod 3 by reciprocal multiplication
  localparam int MOD3_K = CB + 1;
  localparam logic [CB:0] RECIP3 = (CB+1)'(((1 << MOD3_K) + 2) / 3);

  smpe_pkg::eng_state_t state, state_next;
  smpe_pkg::job_t cur;
  logic signed [31:0] za, zb, zx, zy;
  logic signed [63:0] p0, p1, p2;
  logic signed [63:0] lin_x, lin_y_d;
  logic [47:0] mag_now;
  logic [CB:0] count;
  logic [7:0] r, g, bl;
  logic [10:0] hv;
  logic [CB+16:0] hraw;
  logic [CB-1:0] hq, hdiv3, hrem;
  logic [2*CB:0] hprod;
  logic [9:0] sr, sg, sb;
  logic [24:0] wr, wg, wb;
  logic escaped;

  // shared multiplier operands
  logic signed [31:0] m0a, m0b, m1a, m1b, m2a, m2b;
  always_comb begin
    m0a = za; m0b = za; m1a = zb; m1b = zb; m2a = '0; m2b = '0;
    unique case (state)
      smpe_pkg::ST_LIN: begin
        m0a = regs.coef_a; m0b = za; m1a = regs.coef_b; m1b = zb;
        m2a = regs.coef_d; m2b = zb;
      end
      smpe_pkg::ST_LINSUM: begin
        m0a = regs.coef_b; m0b = za; m1a = '0; m1b = '0; m2a = '0; m2b = '0;
      end
      smpe_pkg::ST_SQMUL: begin
        m0a = zx; m0b = zx; m1a = zy; m1b = zy; m2a = zx; m2b = zy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    p0 <= m0a * m0b;
    p1 <= m1a * m1b;
    p2 <= m2a * m2b;
  end

  // squares of za/zb land in p0/p1 in the cycle after ST_MAG, in ST_CHECK
  assign mag_now = 48'(p0 >>> F) + 48'(p1 >>> F);

  assign job_ready = (state == smpe_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      smpe_pkg::ST_IDLE:   if (job_valid) state_next = smpe_pkg::ST_MAG;
      smpe_pkg::ST_MAG:    state_next = smpe_pkg::ST_CHECK;
      smpe_pkg::ST_CHECK:
        if (mag_now <= regs.escape_sq && count <= {1'b0, cur.limit})
          state_next = smpe_pkg::ST_LIN;
        else state_next = smpe_pkg::ST_HUE;
      smpe_pkg::ST_LIN:    state_next = smpe_pkg::ST_LINSUM;
      smpe_pkg::ST_LINSUM: state_next = smpe_pkg::ST_SQ;
      smpe_pkg::ST_SQ:     state_next = smpe_pkg::ST_SQMUL;
      smpe_pkg::ST_SQMUL:  state_next = smpe_pkg::ST_SQSUM;
      smpe_pkg::ST_SQSUM:  state_next = smpe_pkg::ST_MAG;
      smpe_pkg::ST_HUE:    state_next = smpe_pkg::ST_MOD;
      smpe_pkg::ST_MOD:    state_next = smpe_pkg::ST_WEIGHT;
      smpe_pkg::ST_WEIGHT: state_next = smpe_pkg::ST_ACC;
      smpe_pkg::ST_ACC:    state_next = cur.last_sample ? smpe_pkg::ST_EMIT
                                                        : smpe_pkg::ST_IDLE;
      smpe_pkg::ST_EMIT:   if (out_ready) state_next = smpe_pkg::ST_IDLE;
      default:             state_next = smpe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state == smpe_pkg::ST_EMIT);
    out_data.red   = (sr > 10'd255) ? 8'd255 : sr[7:0];
    out_data.green = (sg > 10'd255) ? 8'd255 : sg[7:0];
    out_data.blue  = (sb > 10'd255) ? 8'd255 : sb[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= smpe_pkg::ST_IDLE;
    else     state <= state_next;
  end

  function automatic logic [9:0] acc(input logic [9:0] s, input logic [24:0] w);
    logic [25:0] t;
    t = 26'(s) + 26'(w[24:16]);
    return (t > 26'd1023) ? 10'd1023 : t[9:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sr <= '0; sg <= '0; sb <= '0;
    end else if (state == smpe_pkg::ST_ACC) begin
      sr <= acc(sr, wr); sg <= acc(sg, wg); sb <= acc(sb, wb);
    end else if (state == smpe_pkg::ST_EMIT && out_ready) begin
      sr <= '0; sg <= '0; sb <= '0;
    end
  end

  // hue / 512 is below 2^CB, so the reciprocal quotient is exact
  assign hq    = hraw[CB+8:9];
  assign hprod = (2*CB+1)'(hq) * (2*CB+1)'(RECIP3);
  assign hdiv3 = hprod[2*CB:MOD3_K];
  assign hrem  = hq - (hdiv3 << 1) - hdiv3;

  // datapath; >>> on signed products is floor truncation
  always_ff @(posedge clk) begin
    unique case (state)
      smpe_pkg::ST_IDLE: begin
        cur <= job; za <= job.point_re; zb <= job.point_im; count <= '0;
      end
      smpe_pkg::ST_LINSUM: begin
        lin_x   <= (p0 >>> F) + (p1 >>> F);
        lin_y_d <= p2 >>> F;
      end
      smpe_pkg::ST_SQ: begin
        zx <= smpe_pkg::sat32(66'(lin_x));
        zy <= smpe_pkg::sat32(66'((p0 >>> F) + lin_y_d));
        count <= count + 1'b1;
      end
      smpe_pkg::ST_SQSUM: begin
        za <= smpe_pkg::sat32(66'(p0 >>> F) - 66'(p1 >>> F) + 66'(cur.point_re));
        zb <= smpe_pkg::sat32(66'(p2 >>> (F-1)) + 66'(cur.point_im));
      end
      smpe_pkg::ST_HUE: hraw <= (CB+17)'((33'(count) * 33'(regs.colour_scale)) >> 8)
                                + (CB+17)'(regs.colour_offset);
      smpe_pkg::ST_MOD: hraw <= (CB+17)'({hrem[1:0], hraw[8:0]});
      default: ;
    endcase
  end

  always_comb begin
    hv = hraw[10:0];
    r = 8'd0; g = 8'd0; bl = 8'd0;
    if (hv < 11'd256)       begin r = 8'd255; bl = hv[7:0]; end
    else if (hv < 11'd512)  begin bl = 8'd255;
      r = (hv == 11'd256) ? 8'd255 : 8'(11'd512 - hv); end
    else if (hv < 11'd768)  begin bl = 8'd255; g = 8'(hv - 11'd512); end
    else if (hv < 11'd1024) begin g = 8'd255;
      bl = (hv == 11'd768) ? 8'd255 : 8'(11'd1024 - hv); end
    else if (hv < 11'd1280) begin g = 8'd255; r = 8'(hv - 11'd1024); end
    else begin r = 8'd255;
      g = (hv == 11'd1280) ? 8'd255 : 8'(11'd1536 - hv); end
  end

  always_ff @(posedge clk) begin
    if (state == smpe_pkg::ST_CHECK) escaped <= (mag_now > regs.escape_sq);
    if (state == smpe_pkg::ST_WEIGHT) begin
      wr <= escaped ? 25'(r)  * 25'(regs.sample_weight) : '0;
      wg <= escaped ? 25'(g)  * 25'(regs.sample_weight) : '0;
      wb <= escaped ? 25'(bl) * 25'(regs.sample_weight) : '0;
    end
  end

  `SMPE_ASSERT(a_emit_last, clk, rst, out_valid |-> cur.last_sample)
  `SMPE_ASSERT(a_emit_hold, clk, rst, (out_valid && !out_ready) |=> out_valid)
  `SMPE_ASSERT(a_count_bound, clk, rst,
    state == smpe_pkg::ST_LIN |-> count <= {1'b0, cur.limit})
endmodule

// ----- rtl/stretched_mandelbrot_pixel_engine_top.sv -----
// ----------------------------------------------------------------------------
// stretched_mandelbrot_pixel_engine_top
// Escape-time pixel engine with stretched matrix and hue ramp.
// ----------------------------------------------------------------------------
// channel | handshake            | payload
// cfg     | cfg_valid/cfg_ready  | cfg (index, data)
// in      | in_valid/in_ready    | in_data (point_re, point_im, last_sample)
// out     | out_valid/out_ready  | out_data (red, green, blue)
// A sample runs n escape iterations in the back end (at most limit+1) on the
// three shared multipliers; a sample that ends a pixel also waits for the
// pixel transaction.
// A two-entry queue holds samples while the back end iterates.
// Reset is synchronous; the color sums clear on reset and after each pixel.
// A pending pixel holds the back end until out_ready.
// ----------------------------------------------------------------------------
module stretched_mandelbrot_pixel_engine_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  smpe_pkg::cfg_item_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  smpe_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output smpe_pkg::out_item_t out_data
);
  smpe_pkg::cfg_regs_t regs;
  smpe_pkg::job_t job;
  logic job_valid, job_ready;

  smpe_front u_front (.clk, .rst, .cfg_valid, .cfg_ready, .cfg, .in_valid, .in_ready,
    .in_data, .regs, .job_valid, .job_ready, .job);
  smpe_back u_back (.clk, .rst, .regs, .job_valid, .job_ready, .job, .out_valid,
    .out_ready, .out_data);
endmodule

// ----- tb/sv/smpe_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smpe_checker
// Watches the config, sample and pixel channels of the pixel engine, keeps
// its own copy of the registers and color sums, works out each pixel from the
// accepted samples and compares every pixel transaction with the oldest one
// still expected.
// ----------------------------------------------------------------------------
module smpe_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  smpe_pkg::cfg_item_t  cfg,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  smpe_pkg::in_item_t   in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  smpe_pkg::out_item_t  out_data,
  output int                   errors,
  output int                   pending
);
  smpe_pkg::cfg_regs_t regs;
  int        acc_red, acc_green, acc_blue;
  smpe_pkg::out_item_t pixel_q[$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag2(input longint x, input longint y);
    return ((x * x) >>> smpe_pkg::FRAC_BITS) + ((y * y) >>> smpe_pkg::FRAC_BITS);
  endfunction

  // Escape-time iteration and hue ramp for one sample point
  function automatic void sample_colour(input longint cre, input longint cim,
                                        output int r, output int g, output int b);
    longint za, zb, zx, zy, ca, cb, cd, esc, hue;
    longint count, lim;
    ca = longint'(regs.coef_a);
    cb = longint'(regs.coef_b);
    cd = longint'(regs.coef_d);
    esc = longint'({16'd0, regs.escape_sq});
    lim = longint'(regs.max_iter);
    za = cre;
    zb = cim;
    count = 0;
    r = 0;
    g = 0;
    b = 0;
    while (mag2(za, zb) <= esc && count <= lim) begin
      count++;
      zx = clamp32(((ca * za) >>> smpe_pkg::FRAC_BITS) +
                   ((cb * zb) >>> smpe_pkg::FRAC_BITS));
      zy = clamp32(((cb * za) >>> smpe_pkg::FRAC_BITS) +
                   ((cd * zb) >>> smpe_pkg::FRAC_BITS));
      za = clamp32(((zx * zx) >>> smpe_pkg::FRAC_BITS) -
                   ((zy * zy) >>> smpe_pkg::FRAC_BITS) + cre);
      zb = clamp32(((zx * zy) >>> (smpe_pkg::FRAC_BITS - 1)) + cim);
    end
    if (mag2(za, zb) > esc) begin
      hue = ((count * longint'(regs.colour_scale)) >> 8) + longint'(regs.colour_offset);
      hue = hue % 1536;
      if (hue < 256) begin
        r = 255; b = int'(hue);
      end else if (hue < 512) begin
        b = 255; r = int'(512 - hue);
      end else if (hue < 768) begin
        b = 255; g = int'(hue - 512);
      end else if (hue < 1024) begin
        g = 255; b = int'(1024 - hue);
      end else if (hue < 1280) begin
        g = 255; r = int'(hue - 1024);
      end else begin
        r = 255; g = int'(1536 - hue);
      end
      // falling edges hit 256 at the segment start
      if (r > 255) r = 255;
      if (g > 255) g = 255;
      if (b > 255) b = 255;
    end
  endfunction

  function automatic int add_weighted(input int acc, input int chan);
    int sum;
    sum = acc + ((chan * int'(regs.sample_weight)) >>> 16);
    return (sum > 1023) ? 1023 : sum;
  endfunction

  always @(posedge clk) begin
    int r, g, b;
    smpe_pkg::out_item_t want;
    if (rst) begin
      regs.coef_a        = 32'sd16777216;
      regs.coef_b        = 32'sd0;
      regs.coef_d        = 32'sd16777216;
      regs.escape_sq     = 48'd67108864;
      regs.max_iter      = 16'd255;
      regs.colour_scale  = 16'd256;
      regs.colour_offset = 11'd0;
      regs.sample_weight = 17'd65536;
      acc_red   = 0;
      acc_green = 0;
      acc_blue  = 0;
      pixel_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg.index)
          smpe_pkg::REG_COEF_A: regs.coef_a        = cfg.data[31:0];
          smpe_pkg::REG_COEF_B: regs.coef_b        = cfg.data[31:0];
          smpe_pkg::REG_COEF_D: regs.coef_d        = cfg.data[31:0];
          smpe_pkg::REG_ESCAPE: regs.escape_sq     = cfg.data[47:0];
          smpe_pkg::REG_MAXIT:  regs.max_iter      = cfg.data[15:0];
          smpe_pkg::REG_CSCALE: regs.colour_scale  = cfg.data[15:0];
          smpe_pkg::REG_COFFS:  regs.colour_offset = cfg.data[10:0];
          smpe_pkg::REG_WEIGHT: regs.sample_weight = cfg.data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        sample_colour(longint'(in_data.point_re), longint'(in_data.point_im), r, g, b);
        acc_red   = add_weighted(acc_red, r);
        acc_green = add_weighted(acc_green, g);
        acc_blue  = add_weighted(acc_blue, b);
        if (in_data.last_sample) begin
          want.red   = (acc_red > 255) ? 8'd255 : acc_red[7:0];
          want.green = (acc_green > 255) ? 8'd255 : acc_green[7:0];
          want.blue  = (acc_blue > 255) ? 8'd255 : acc_blue[7:0];
          pixel_q.push_back(want);
          acc_red   = 0;
          acc_green = 0;
          acc_blue  = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel transaction with none expected: %0d %0d %0d",
                 out_data.red, out_data.green, out_data.blue);
          errors <= errors + 1;
        end else begin
          want = pixel_q.pop_front();
          if (out_data != want) begin
            if (out_data.red != want.red)
              $error("red: expected %0d, got %0d", want.red, out_data.red);
            if (out_data.green != want.green)
              $error("green: expected %0d, got %0d", want.green, out_data.green);
            if (out_data.blue != want.blue)
              $error("blue: expected %0d, got %0d", want.blue, out_data.blue);
            errors <= errors + 1;
          end
        end
      end
      pending <= pixel_q.size();
    end
  end
endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the pixel engine with directed and random sample points under
// several register settings and varying back-pressure; the checker predicts
// and compares every pixel.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int STALL_LIMIT = 200000;
  localparam int ONE = 16777216;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  smpe_pkg::cfg_item_t cfg = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  smpe_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  smpe_pkg::out_item_t out_data;
  int        errors;
  int        pending;
  int        tx_idle = 0;
  int        rx_idle = 0;
  int        stall_cycles = 0;

  always #5 clk = ~clk;

  stretched_mandelbrot_pixel_engine_top u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  smpe_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .errors(errors), .pending(pending)
  );

  always @(negedge clk) begin
    out_ready <= (int'($urandom_range(99)) >= rx_idle);
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [smpe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Called right after a transaction edge; ends on the accepting edge
  task automatic send_point(input logic [31:0] re, input logic [31:0] im, input logic last);
    while (int'($urandom_range(99)) < tx_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data.point_re    <= re;
    in_data.point_im    <= im;
    in_data.last_sample <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait for every pixel, then let the back end settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(input int span, input int base);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'(int'($urandom_range(span)) - base);
    endcase
  endfunction

  task automatic random_points(input int n);
    logic last;
    for (int i = 0; i < n; i++) begin
      last = (i == n - 1) || ($urandom_range(3) == 0);
      send_point(rand_coord(53687091, 36909875), rand_coord(50331648, 25165824), last);
    end
    drain();
  endtask

  task automatic random_setup();
    logic [47:0] esc;
    case ($urandom_range(4))
      0: write_reg(smpe_pkg::REG_COEF_A, 48'($urandom));
      default: write_reg(smpe_pkg::REG_COEF_A,
                         48'(32'(ONE - 8388608 + int'($urandom_range(16777216)))));
    endcase
    write_reg(smpe_pkg::REG_COEF_B, 48'(32'(int'($urandom_range(8388608)) - 4194304)));
    write_reg(smpe_pkg::REG_COEF_D,
              48'(32'(ONE - 8388608 + int'($urandom_range(16777216)))));
    case ($urandom_range(3))
      0: esc = 48'd67108864;
      1: esc = 48'({$urandom, $urandom});
      default: esc = 48'($urandom_range(32'h4000_0000));
    endcase
    write_reg(smpe_pkg::REG_ESCAPE, esc);
    write_reg(smpe_pkg::REG_MAXIT, 48'($urandom_range(40)));
    write_reg(smpe_pkg::REG_CSCALE, 48'($urandom_range(65535)));
    write_reg(smpe_pkg::REG_COFFS, 48'($urandom_range(2047)));
    case ($urandom_range(2))
      0: write_reg(smpe_pkg::REG_WEIGHT, 48'd65536);
      1: write_reg(smpe_pkg::REG_WEIGHT, 48'd16384);
      default: write_reg(smpe_pkg::REG_WEIGHT, 48'($urandom_range(131071)));
    endcase
  endtask

  initial begin
    int ramp_edge[8];
    ramp_edge = '{255, 256, 512, 768, 1024, 1280, 1535, 2047};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: black, quick escape, extremes, boundary points
    send_point(32'd0, 32'd0, 1'b0);
    send_point(32'(3 * ONE), 32'd0, 1'b0);
    send_point(32'h80000000, 32'h7fffffff, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 1'b1);
    send_point(32'(-ONE * 3 / 4), 32'(ONE / 10), 1'b1);
    send_point(32'(ONE * 26 / 100), 32'd0, 1'b1);
    send_point(32'h80000000, 32'h80000000, 1'b1);
    send_point(32'h7fffffff, 32'h7fffffff, 1'b0);
    send_point(32'hffffffff, 32'hffffffff, 1'b1);
    drain();

    // hue ramp edges: with zero scale the hue is the offset itself
    write_reg(smpe_pkg::REG_CSCALE, 48'd0);
    foreach (ramp_edge[k]) begin
      write_reg(smpe_pkg::REG_COFFS, 48'(ramp_edge[k]));
      send_point(32'(3 * ONE), 32'd0, 1'b1);
      drain();
    end

    // sum saturation and weight extremes
    write_reg(smpe_pkg::REG_COFFS, 48'd0);
    repeat (5) send_point(32'(3 * ONE), 32'd0, 1'b0);
    send_point(32'(-3 * ONE), 32'd0, 1'b1);
    drain();
    write_reg(smpe_pkg::REG_WEIGHT, 48'd131071);
    send_point(32'(3 * ONE), 32'(ONE), 1'b1);
    drain();
    write_reg(smpe_pkg::REG_WEIGHT, 48'd0);
    send_point(32'(3 * ONE), 32'(ONE), 1'b1);
    drain();
    write_reg(smpe_pkg::REG_WEIGHT, 48'd65536);
    write_reg(smpe_pkg::REG_CSCALE, 48'd65535);

    // largest limit: only points that escape at once
    write_reg(smpe_pkg::REG_ESCAPE, 48'd0);
    write_reg(smpe_pkg::REG_MAXIT, 48'd65535);
    for (int i = 0; i < 4; i++)
      send_point(32'((1 << 20) + int'($urandom_range(1 << 24))),
                 32'(-int'($urandom_range(1 << 24))), i == 3);
    drain();

    // nothing escapes; then zero limit
    write_reg(smpe_pkg::REG_ESCAPE, 48'hffff_ffff_ffff);
    write_reg(smpe_pkg::REG_MAXIT, 48'd3);
    random_points(4);
    write_reg(smpe_pkg::REG_ESCAPE, 48'd67108864);
    write_reg(smpe_pkg::REG_MAXIT, 48'd0);
    random_points(6);

    // coefficient extremes drive the z parts into saturation
    write_reg(smpe_pkg::REG_COEF_A, 48'h0000_8000_0000);
    write_reg(smpe_pkg::REG_COEF_B, 48'h0000_7fff_ffff);
    write_reg(smpe_pkg::REG_COEF_D, 48'h0000_8000_0000);
    write_reg(smpe_pkg::REG_MAXIT, 48'd5);
    random_points(6);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 37 : (ph == 1) ? 55 : 0;
      rx_idle = (ph == 0) ? 55 : (ph == 1) ? 37 : 0;
      for (int k = 0; k < 4; k++) begin
        random_setup();
        random_points(65);
      end
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ----- stretched_mandelbrot_pixel_engine_top.f -----
+incdir+rtl
rtl/smpe_pkg.sv
rtl/smpe_front.sv
rtl/smpe_back.sv
rtl/stretched_mandelbrot_pixel_engine_top.sv
tb/sv/smpe_checker.sv
tb/sv/tb_top.sv
